// ----- sv/mfa_pkg.sv -----
`timescale 1ns / 1ps
package mfa_pkg;

  localparam int FIELD_W           = 32;
  localparam int CALC_W            = 64;
  localparam int DEFAULT_WORD_BITS = 32;
  localparam int IN_DATA_W         = 192;
  localparam int IN_USER_W         = 3;
  localparam int OUT_DATA_W        = 104;
  localparam int OUT_USER_W        = 2;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_LT  = 3'd4,
    MODE_GT  = 3'd5,
    MODE_LE  = 3'd6,
    MODE_GE  = 3'd7
  } mode_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_R = 2'd2
  } phase_t;

  typedef enum logic {
    CTX_NORM = 1'b0,
    CTX_LCM  = 1'b1
  } ctx_t;

  typedef enum logic [5:0] {
    S_IDLE, S_WAIT, S_NDIV, S_NQ, S_GCD, S_GSTEP, S_NDN, S_NDD, S_NEND, S_NDISP,
    S_L1, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7, S_L8,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_RCHK,
    S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7,
    S_OVF, S_OUT
  } state_t;

  // request and answer between the sequencer and the shared mul/div unit
  typedef struct packed {
    logic              start;
    op_t               op;
    logic [CALC_W-1:0] a;
    logic [CALC_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic [CALC_W-1:0] q;
    logic [CALC_W-1:0] r;
    logic              ovf;
  } unit_rsp_t;

endpackage

// ----- sv/mfa_muldiv.sv -----
`timescale 1ns / 1ps
module mfa_muldiv (
  input  logic               clk,
  input  logic               rst_n,
  input  mfa_pkg::unit_req_t req,
  output mfa_pkg::unit_rsp_t rsp
);
  import mfa_pkg::*;

  localparam int CNT_W = $clog2(CALC_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  op_t               op_r, op_nxt;
  logic [CALC_W-1:0] acc_r, acc_nxt;
  logic [CALC_W-1:0] sh_r, sh_nxt;
  logic [CALC_W-1:0] mb_r, mb_nxt;
  logic              negq_r, negq_nxt;
  logic              negr_r, negr_nxt;
  logic              bzero_r, bzero_nxt;
  logic              dovf_r, dovf_nxt;

  logic [CALC_W:0]   lhs, rhs;
  logic [CALC_W+1:0] sum;
  logic              cin;
  logic [CALC_W-1:0] mag_a, mag_b, neg_sh, neg_acc;
  logic              mul_ovf;

  // one shared adder: trial subtract for divide, accumulate for multiply
  always_comb begin
    if (op_r == OP_DIV) begin
      lhs = {acc_r, sh_r[CALC_W-1]};
      rhs = ~{1'b0, mb_r};
      cin = 1'b1;
    end else begin
      lhs = {1'b0, acc_r};
      rhs = sh_r[0] ? {1'b0, mb_r} : '0;
      cin = 1'b0;
    end
    sum = {1'b0, lhs} + {1'b0, rhs} + {{(CALC_W+1){1'b0}}, cin};
  end

  assign mag_a   = req.a[CALC_W-1] ? (CALC_W'(0) - req.a) : req.a;
  assign mag_b   = req.b[CALC_W-1] ? (CALC_W'(0) - req.b) : req.b;
  assign neg_sh  = CALC_W'(0) - sh_r;
  assign neg_acc = CALC_W'(0) - acc_r;

  always_comb begin
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    mb_nxt    = mb_r;
    negq_nxt  = negq_r;
    negr_nxt  = negr_r;
    bzero_nxt = bzero_r;
    dovf_nxt  = dovf_r;
    if (req.start) begin
      run_nxt   = 1'b1;
      cnt_nxt   = '0;
      op_nxt    = req.op;
      acc_nxt   = '0;
      sh_nxt    = mag_a;
      mb_nxt    = mag_b;
      negq_nxt  = req.a[CALC_W-1] ^ req.b[CALC_W-1];
      negr_nxt  = req.a[CALC_W-1];
      bzero_nxt = (req.b == '0);
      dovf_nxt  = (req.b == '1) && (req.a == {1'b1, {(CALC_W-1){1'b0}}});
    end else if (run_r) begin
      if (op_r == OP_DIV) begin
        if (sum[CALC_W+1]) begin
          acc_nxt = sum[CALC_W-1:0];
        end else begin
          acc_nxt = lhs[CALC_W-1:0];
        end
        sh_nxt = {sh_r[CALC_W-2:0], sum[CALC_W+1]};
      end else begin
        acc_nxt = sum[CALC_W:1];
        sh_nxt  = {sum[0], sh_r[CALC_W-1:1]};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CALC_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    op_r    <= op_nxt;
    acc_r   <= acc_nxt;
    sh_r    <= sh_nxt;
    mb_r    <= mb_nxt;
    negq_r  <= negq_nxt;
    negr_r  <= negr_nxt;
    bzero_r <= bzero_nxt;
    dovf_r  <= dovf_nxt;
  end

  // magnitude product must fit the signed range of its sign
  assign mul_ovf = (acc_r != '0) ||
                   (negq_r ? (sh_r[CALC_W-1] && (sh_r[CALC_W-2:0] != '0)) : sh_r[CALC_W-1]);

  always_comb begin
    rsp.done = done_r;
    if (op_r == OP_MUL) begin
      rsp.q   = negq_r ? neg_sh : sh_r;
      rsp.r   = '0;
      rsp.ovf = mul_ovf;
    end else begin
      rsp.q   = bzero_r ? '0 : (negq_r ? neg_sh : sh_r);
      rsp.r   = bzero_r ? '0 : (negr_r ? neg_acc : acc_r);
      rsp.ovf = dovf_r;
    end
  end

endmodule

// ----- sv/mixed_fraction_alu.sv -----
`timescale 1ns / 1ps
// Mixed fraction ALU: takes two operands (whole, num, den) and a mode on in_tuser
// (add, sub, mul, div, or one of four comparisons) and returns one normalized
// mixed fraction with zero-denominator and overflow flags. Each operand and the
// arithmetic result are reduced with a Euclid GCD, so the denominator follows C
// remainder signs and may come out negative. All multiplies, divides and
// remainders run on one shared shift-and-add unit, and the sequencer waits in
// S_WAIT for each answer. The work of an item is the operations it needs: each
// normalization takes 3 divides plus one divide per Euclid step (two
// normalizations for a compare, three for arithmetic), add and sub add a Euclid
// run and 6 more multiplies or divides, mul and div 4 multiplies, a compare up
// to 3 multiplies. A zero operand denominator goes straight to the output
// state without using the unit. The block takes one item at a time and accepts
// the next after the result transfer.
module mixed_fraction_alu #(
  parameter int WORD_BITS = mfa_pkg::DEFAULT_WORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // a_whole, a_num, a_den, b_whole, b_num, b_den
  input  logic [mfa_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic [mfa_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // res_whole, res_num, res_den, compare_true, zero padding
  output logic [mfa_pkg::OUT_DATA_W-1:0] out_tdata,
  // zero_denominator, overflow
  output logic [mfa_pkg::OUT_USER_W-1:0] out_tuser
);
  import mfa_pkg::*;

  state_t            state_r, state_nxt;
  state_t            ret_r, ret_nxt;
  phase_t            phase_r, phase_nxt;
  ctx_t              ctx_r, ctx_nxt;
  mode_t             mode_r, mode_nxt;
  logic [CALC_W-1:0] w_r, w_nxt, n_r, n_nxt, d_r, d_nxt;
  logic [CALC_W-1:0] wa_r, wa_nxt, na_r, na_nxt, da_r, da_nxt;
  logic [CALC_W-1:0] wb_r, wb_nxt, nb_r, nb_nxt, db_r, db_nxt;
  logic [CALC_W-1:0] x_r, x_nxt, y_r, y_nxt, g_r, g_nxt;
  logic [CALC_W-1:0] l_r, l_nxt, ta_r, ta_nxt, tb_r, tb_nxt;
  logic              dwp_r, dwp_nxt, dwn_r, dwn_nxt, flip_r, flip_nxt;
  logic [FIELD_W-1:0] rw_r, rw_nxt, rn_r, rn_nxt, rd_r, rd_nxt;
  logic              cmp_r, cmp_nxt, zd_r, zd_nxt, of_r, of_nxt;

  logic [CALC_W-1:0] add_a, add_b, add_bb, add_y;
  logic              add_sub, add_ovf;
  logic              gt, lt;

  unit_req_t req;
  unit_rsp_t rsp;

  mfa_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  function automatic logic [CALC_W-1:0] sext(input logic [FIELD_W-1:0] v);
    return {{(CALC_W-FIELD_W){v[FIELD_W-1]}}, v};
  endfunction

  function automatic logic fits(input logic [CALC_W-1:0] v);
    logic [CALC_W-1:0] s;
    s = $signed(v) >>> (WORD_BITS - 1);
    return (s == '0) || (s == '1);
  endfunction

  function automatic logic cmp_pick(input mode_t m, input logic g_, input logic l_);
    logic res;
    unique case (m)
      MODE_LT: res = l_;
      MODE_GT: res = g_;
      MODE_LE: res = !g_;
      MODE_GE: res = !l_;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  // operand select for the shared 64-bit adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      S_NQ: begin
        add_a = w_r;
        add_b = rsp.q;
      end
      S_L7: begin
        add_a   = wa_r;
        add_b   = wb_r;
        add_sub = (mode_r == MODE_SUB);
      end
      S_L8: begin
        add_a   = ta_r;
        add_b   = tb_r;
        add_sub = (mode_r == MODE_SUB);
      end
      S_M2: begin
        add_a = na_r;
        add_b = rsp.q;
      end
      S_M3: begin
        add_a = nb_r;
        add_b = rsp.q;
      end
      S_C0: begin
        add_a   = wa_r;
        add_b   = wb_r;
        add_sub = 1'b1;
      end
      S_C3: begin
        add_a   = ta_r;
        add_b   = rsp.q;
        add_sub = 1'b1;
      end
      S_C4: begin
        add_b   = l_r;
        add_sub = 1'b1;
      end
      S_C5: begin
        add_b   = tb_r;
        add_sub = 1'b1;
      end
      S_C6: begin
        add_b   = l_r;
        add_sub = dwp_r;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_bb  = add_sub ? ~add_b : add_b;
  assign add_y   = add_a + add_bb + {{(CALC_W-1){1'b0}}, add_sub};
  assign add_ovf = (add_a[CALC_W-1] == add_bb[CALC_W-1]) &&
                   (add_y[CALC_W-1] != add_a[CALC_W-1]);

  assign gt = $signed(tb_r) > $signed(ta_r);
  assign lt = $signed(tb_r) < $signed(ta_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {{(OUT_DATA_W-3*FIELD_W-1){1'b0}}, cmp_r, rd_r, rn_r, rw_r};
  assign out_tuser  = {of_r, zd_r};

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    phase_nxt = phase_r;
    ctx_nxt   = ctx_r;
    mode_nxt  = mode_r;
    w_nxt = w_r;   n_nxt = n_r;   d_nxt = d_r;
    wa_nxt = wa_r; na_nxt = na_r; da_nxt = da_r;
    wb_nxt = wb_r; nb_nxt = nb_r; db_nxt = db_r;
    x_nxt = x_r;   y_nxt = y_r;   g_nxt = g_r;
    l_nxt = l_r;   ta_nxt = ta_r; tb_nxt = tb_r;
    dwp_nxt = dwp_r; dwn_nxt = dwn_r; flip_nxt = flip_r;
    rw_nxt = rw_r; rn_nxt = rn_r; rd_nxt = rd_r;
    cmp_nxt = cmp_r; zd_nxt = zd_r; of_nxt = of_r;
    req.start = 1'b0;
    req.op    = OP_DIV;
    req.a     = '0;
    req.b     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = mode_t'(in_tuser[2:0]);
          w_nxt  = sext(in_tdata[31:0]);
          n_nxt  = sext(in_tdata[63:32]);
          d_nxt  = sext(in_tdata[95:64]);
          wb_nxt = sext(in_tdata[127:96]);
          nb_nxt = sext(in_tdata[159:128]);
          db_nxt = sext(in_tdata[191:160]);
          rw_nxt = '0; rn_nxt = '0; rd_nxt = '0;
          cmp_nxt = 1'b0; zd_nxt = 1'b0; of_nxt = 1'b0;
          phase_nxt = PH_A;
          if (in_tdata[95:64] == '0 || in_tdata[191:160] == '0) begin
            zd_nxt    = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_NDIV;
          end
        end
      end
      S_WAIT: begin
        if (rsp.done) state_nxt = ret_r;
      end
      S_NDIV: begin
        req.start = 1'b1; req.op = OP_DIV; req.a = n_r; req.b = d_r;
        ret_nxt = S_NQ; state_nxt = S_WAIT;
      end
      S_NQ: begin
        if (rsp.ovf || add_ovf) begin
          state_nxt = S_OVF;
        end else begin
          w_nxt = add_y; n_nxt = rsp.r;
          x_nxt = rsp.r; y_nxt = d_r;
          ctx_nxt = CTX_NORM; state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (y_r == '0) begin
          g_nxt = x_r;
          state_nxt = (ctx_r == CTX_NORM) ? S_NDN : S_L1;
        end else begin
          req.start = 1'b1; req.op = OP_DIV; req.a = x_r; req.b = y_r;
          ret_nxt = S_GSTEP; state_nxt = S_WAIT;
        end
      end
      S_GSTEP: begin
        x_nxt = y_r; y_nxt = rsp.r;
        state_nxt = S_GCD;
      end
      S_NDN: begin
        req.start = 1'b1; req.op = OP_DIV; req.a = n_r; req.b = g_r;
        ret_nxt = S_NDD; state_nxt = S_WAIT;
      end
      S_NDD: begin
        if (rsp.ovf) begin
          state_nxt = S_OVF;
        end else begin
          n_nxt = rsp.q;
          req.start = 1'b1; req.op = OP_DIV; req.a = d_r; req.b = g_r;
          ret_nxt = S_NEND; state_nxt = S_WAIT;
        end
      end
      S_NEND: begin
        if (rsp.ovf) begin
          state_nxt = S_OVF;
        end else begin
          d_nxt = rsp.q;
          state_nxt = S_NDISP;
        end
      end
      S_NDISP: begin
        unique case (phase_r)
          PH_A: begin
            wa_nxt = w_r; na_nxt = n_r; da_nxt = d_r;
            w_nxt = wb_r; n_nxt = nb_r; d_nxt = db_r;
            phase_nxt = PH_B; state_nxt = S_NDIV;
          end
          PH_B: begin
            wb_nxt = w_r; nb_nxt = n_r; db_nxt = d_r;
            if (mode_r[2]) begin
              state_nxt = S_C0;
            end else if (!mode_r[1]) begin
              x_nxt = da_r; y_nxt = d_r;
              ctx_nxt = CTX_LCM; state_nxt = S_GCD;
            end else begin
              state_nxt = S_M1;
            end
          end
          PH_R: begin
            if (fits(w_r) && fits(n_r) && fits(d_r)) begin
              rw_nxt = w_r[FIELD_W-1:0];
              rn_nxt = n_r[FIELD_W-1:0];
              rd_nxt = d_r[FIELD_W-1:0];
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_OVF;
            end
          end
          default: state_nxt = S_OVF;
        endcase
      end
      // common denominator: l = (da / gcd) * db
      S_L1: begin
        req.start = 1'b1; req.op = OP_DIV; req.a = da_r; req.b = g_r;
        ret_nxt = S_L2; state_nxt = S_WAIT;
      end
      S_L2: begin
        if (rsp.ovf) state_nxt = S_OVF;
        else begin
          req.start = 1'b1; req.op = OP_MUL; req.a = rsp.q; req.b = db_r;
          ret_nxt = S_L3; state_nxt = S_WAIT;
        end
      end
      S_L3: begin
        if (rsp.ovf) state_nxt = S_OVF;
        else begin
          l_nxt = rsp.q;
          req.start = 1'b1; req.op = OP_DIV; req.a = rsp.q; req.b = da_r;
          ret_nxt = S_L4; state_nxt = S_WAIT;
        end
      end
      S_L4: begin
        if (rsp.ovf) state_nxt = S_OVF;
        else begin
          req.start = 1'b1; req.op = OP_MUL; req.a = na_r; req.b = rsp.q;
          ret_nxt = S_L5; state_nxt = S_WAIT;
        end
      end
      S_L5: begin
        if (rsp.ovf) state_nxt = S_OVF;
        else begin
          ta_nxt = rsp.q;
          req.start = 1'b1; req.op = OP_DIV; req.a = l_r; req.b = db_r;
          ret_nxt = S_L6; state_nxt = S_WAIT;
        end
      end
      S_L6: begin
        if (rsp.ovf) state_nxt = S_OVF;
        else begin
          req.start = 1'b1; req.op = OP_MUL; req.a = nb_r; req.b = rsp.q;
          ret_nxt = S_L7; state_nxt = S_WAIT;
        end
      end
      S_L7: begin
        if (rsp.ovf || add_ovf) state_nxt = S_OVF;
        else begin
          tb_nxt = rsp.q; w_nxt = add_y;
          state_nxt = S_L8;
        end
      end
      S_L8: begin
        if (add_ovf) state_nxt = S_OVF;
        else begin
          n_nxt = add_y; d_nxt = l_r;
          state_nxt = S_RCHK;
        end
      end
      // improper numerators: ia = na + wa*da, ib = nb + wb*db
      S_M1: begin
        req.start = 1'b1; req.op = OP_MUL; req.a = wa_r; req.b = da_r;
        ret_nxt = S_M2; state_nxt = S_WAIT;
      end
      S_M2: begin
        if (rsp.ovf || add_ovf) state_nxt = S_OVF;
        else begin
          ta_nxt = add_y;
          req.start = 1'b1; req.op = OP_MUL; req.a = wb_r; req.b = db_r;
          ret_nxt = S_M3; state_nxt = S_WAIT;
        end
      end
      S_M3: begin
        if (rsp.ovf || add_ovf) state_nxt = S_OVF;
        else begin
          tb_nxt = add_y;
          req.start = 1'b1; req.op = OP_MUL; req.a = ta_r;
          req.b = (mode_r == MODE_MUL) ? add_y : db_r;
          ret_nxt = S_M4; state_nxt = S_WAIT;
        end
      end
      S_M4: begin
        if (rsp.ovf) state_nxt = S_OVF;
        else begin
          n_nxt = rsp.q; w_nxt = '0;
          req.start = 1'b1; req.op = OP_MUL; req.a = da_r;
          req.b = (mode_r == MODE_MUL) ? db_r : tb_r;
          ret_nxt = S_M5; state_nxt = S_WAIT;
        end
      end
      S_M5: begin
        if (rsp.ovf) state_nxt = S_OVF;
        else begin
          d_nxt = rsp.q;
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (d_r == '0) begin
          zd_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          phase_nxt = PH_R;
          state_nxt = S_NDIV;
        end
      end
      // compare: whole parts apart by two or more decide alone
      S_C0: begin
        if (!add_y[CALC_W-1] && (add_y[CALC_W-2:1] != '0)) begin
          cmp_nxt = cmp_pick(mode_r, 1'b1, 1'b0);
          state_nxt = S_OUT;
        end else if (add_y[CALC_W-1] && (add_y[CALC_W-2:0] != '1)) begin
          cmp_nxt = cmp_pick(mode_r, 1'b0, 1'b1);
          state_nxt = S_OUT;
        end else begin
          dwp_nxt = (add_y == CALC_W'(1));
          dwn_nxt = (add_y == '1);
          req.start = 1'b1; req.op = OP_MUL; req.a = da_r; req.b = db_r;
          ret_nxt = S_C1; state_nxt = S_WAIT;
        end
      end
      S_C1: begin
        l_nxt = rsp.q;
        req.start = 1'b1; req.op = OP_MUL; req.a = na_r; req.b = db_r;
        ret_nxt = S_C2; state_nxt = S_WAIT;
      end
      S_C2: begin
        ta_nxt = rsp.q;
        req.start = 1'b1; req.op = OP_MUL; req.a = nb_r; req.b = da_r;
        ret_nxt = S_C3; state_nxt = S_WAIT;
      end
      S_C3: begin
        tb_nxt = add_y;
        state_nxt = S_C4;
      end
      S_C4: begin
        flip_nxt = l_r[CALC_W-1];
        if (l_r[CALC_W-1]) l_nxt = add_y;
        state_nxt = S_C5;
      end
      S_C5: begin
        if (flip_r) tb_nxt = add_y;
        state_nxt = S_C6;
      end
      S_C6: begin
        ta_nxt = (dwp_r || dwn_r) ? add_y : '0;
        state_nxt = S_C7;
      end
      S_C7: begin
        cmp_nxt = cmp_pick(mode_r, gt, lt);
        state_nxt = S_OUT;
      end
      S_OVF: begin
        rw_nxt = '0; rn_nxt = '0; rd_nxt = '0;
        cmp_nxt = 1'b0; zd_nxt = 1'b0; of_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      phase_r <= PH_A;
      ctx_r   <= CTX_NORM;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      phase_r <= phase_nxt;
      ctx_r   <= ctx_nxt;
    end
    mode_r <= mode_nxt;
    w_r <= w_nxt;   n_r <= n_nxt;   d_r <= d_nxt;
    wa_r <= wa_nxt; na_r <= na_nxt; da_r <= da_nxt;
    wb_r <= wb_nxt; nb_r <= nb_nxt; db_r <= db_nxt;
    x_r <= x_nxt;   y_r <= y_nxt;   g_r <= g_nxt;
    l_r <= l_nxt;   ta_r <= ta_nxt; tb_r <= tb_nxt;
    dwp_r <= dwp_nxt; dwn_r <= dwn_nxt; flip_r <= flip_nxt;
    rw_r <= rw_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt;
    cmp_r <= cmp_nxt; zd_r <= zd_nxt; of_r <= of_nxt;
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import mfa_pkg::*;

  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
  localparam int     RAND_ITEMS = 1525;
  localparam longint CYCLE_LIMIT = 80_000_000;
  localparam int     HOLD_CYCLES = 6000;

  typedef struct packed {
    logic [31:0] whole;
    logic [31:0] num;
    logic [31:0] den;
    logic        cmp;
    logic        zero_den;
    logic        ovf;
  } fraction_result_t;

  class fraction_scoreboard;
    fraction_result_t expected_q[$];
    int mismatches;
    bit ovf;

    function longint add_chk(longint a, longint b);
      if ((b > 0 && a > I64_MAX - b) || (b < 0 && a < I64_MIN - b)) begin
        ovf = 1;
        return 0;
      end
      return a + b;
    endfunction

    function longint sub_chk(longint a, longint b);
      if ((b < 0 && a > I64_MAX + b) || (b > 0 && a < I64_MIN + b)) begin
        ovf = 1;
        return 0;
      end
      return a - b;
    endfunction

    function longint mul_chk(longint a, longint b);
      bit bad;
      bad = 0;
      if (a == 0 || b == 0) return 0;
      if (a > 0) begin
        if (b > 0) bad = a > I64_MAX / b;
        else bad = b < I64_MIN / a;
      end else begin
        if (b > 0) bad = a < I64_MIN / b;
        else bad = b < I64_MAX / a;
      end
      if (bad) begin
        ovf = 1;
        return 0;
      end
      return a * b;
    endfunction

    function longint div_chk(longint a, longint b);
      if (b == 0) return 0;
      if (b == -1 && a == I64_MIN) begin
        ovf = 1;
        return 0;
      end
      return a / b;
    endfunction

    function longint rem_chk(longint a, longint b);
      if (b == 0 || b == -1) return 0;
      return a % b;
    endfunction

    function longint gcd(longint x, longint y);
      longint t;
      while (y != 0) begin
        t = y;
        y = rem_chk(x, y);
        x = t;
      end
      return x;
    endfunction

    function void reduce(inout longint w, inout longint n, inout longint d);
      longint q, g;
      q = div_chk(n, d);
      w = add_chk(w, q);
      n = rem_chk(n, d);
      g = gcd(n, d);
      n = div_chk(n, g);
      d = div_chk(d, g);
    endfunction

    function int compare(longint wa, longint na, longint da,
                         longint wb, longint nb, longint db);
      longint dw, e, f, t;
      dw = wa - wb;
      if (dw >= 2) return 1;
      if (dw <= -2) return -1;
      e = da * db;
      f = na * db - nb * da;
      if (e < 0) begin
        e = -e;
        f = -f;
      end
      t = -dw * e;
      return f > t ? 1 : (f < t ? -1 : 0);
    endfunction

    function bit fits32(longint v);
      return v >= -(64'sd1 <<< 31) && v <= (64'sd1 <<< 31) - 1;
    endfunction

    function void note_operands(mode_t mode, logic [IN_DATA_W-1:0] data);
      longint wa, na, da, wb, nb, db, rw, rn, rd, l, ta, tb, ia, ib;
      int c;
      fraction_result_t r;
      wa = longint'($signed(data[31:0]));
      na = longint'($signed(data[63:32]));
      da = longint'($signed(data[95:64]));
      wb = longint'($signed(data[127:96]));
      nb = longint'($signed(data[159:128]));
      db = longint'($signed(data[191:160]));
      rw = 0; rn = 0; rd = 0;
      r = '0;
      ovf = 0;
      if (da == 0 || db == 0) begin
        r.zero_den = 1;
      end else begin
        reduce(wa, na, da);
        reduce(wb, nb, db);
        if (mode >= MODE_LT) begin
          c = compare(wa, na, da, wb, nb, db);
          case (mode)
            MODE_LT: r.cmp = c < 0;
            MODE_GT: r.cmp = c > 0;
            MODE_LE: r.cmp = c <= 0;
            default: r.cmp = c >= 0;
          endcase
        end else begin
          if (mode == MODE_ADD || mode == MODE_SUB) begin
            l = mul_chk(div_chk(da, gcd(da, db)), db);
            ta = mul_chk(na, div_chk(l, da));
            tb = mul_chk(nb, div_chk(l, db));
            rw = mode == MODE_ADD ? add_chk(wa, wb) : sub_chk(wa, wb);
            rn = mode == MODE_ADD ? add_chk(ta, tb) : sub_chk(ta, tb);
            rd = l;
          end else begin
            ia = add_chk(na, mul_chk(wa, da));
            ib = add_chk(nb, mul_chk(wb, db));
            if (mode == MODE_MUL) begin
              rn = mul_chk(ia, ib);
              rd = mul_chk(da, db);
            end else begin
              rn = mul_chk(ia, db);
              rd = mul_chk(da, ib);
            end
          end
          if (!ovf && rd == 0) begin
            r.zero_den = 1;
            rw = 0;
            rn = 0;
          end else begin
            reduce(rw, rn, rd);
            if (!ovf && !(fits32(rw) && fits32(rn) && fits32(rd))) ovf = 1;
          end
        end
        if (ovf) begin
          r = '0;
          r.ovf = 1;
          rw = 0; rn = 0; rd = 0;
        end
      end
      r.whole = rw[31:0];
      r.num = rn[31:0];
      r.den = rd[31:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      fraction_result_t e, a;
      a.whole = data[31:0];
      a.num = data[63:32];
      a.den = data[95:64];
      a.cmp = data[96];
      a.zero_den = user[0];
      a.ovf = user[1];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", a);
        return;
      end
      e = expected_q.pop_front();
      if (e.whole !== a.whole || e.num !== a.num || e.den !== a.den || e.cmp !== a.cmp
          || e.zero_den !== a.zero_den || e.ovf !== a.ovf || data[103:97] !== '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p (pad %h)", e, a, data[103:97]);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  fraction_scoreboard sb;
  bit     send_idle_on, recv_idle_on, hold_req;
  int     results_seen;
  longint cycles;

  mixed_fraction_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // note transfers on both sides
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready) sb.note_operands(mode_t'(in_tuser), in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
      results_seen <= results_seen + 1;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int held;
    held = 0;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        held++;
        out_tready <= 0;
      end else begin
        out_tready <= !(recv_idle_on && $urandom_range(99) < 21);
      end
    end
  end

  task automatic send_item(mode_t mode, logic [31:0] aw, an, ad, bw, bn, bd);
    while (send_idle_on && $urandom_range(99) < 21) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {bd, bn, bw, ad, an, aw};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value(bit is_den);
    int k;
    k = $urandom_range(99);
    if (is_den && k < 3) return 0;
    if (k < 60) return $urandom_range(40) - 20;
    if (k < 80) return $urandom_range(2000) - 1000;
    return $urandom;
  endfunction

  initial begin
    mode_t m;
    sb = new();
    cycles = 0;
    results_seen = 0;
    send_idle_on = 1;
    recv_idle_on = 1;
    hold_req = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // each operation on plain fractions, negative denominators, improper parts
    send_item(MODE_ADD, 1, 1, 2, 2, 1, 3);
    send_item(MODE_SUB, 1, 1, 2, 2, 1, 3);
    send_item(MODE_MUL, -3, 7, 4, 2, -5, -6);
    send_item(MODE_DIV, 5, 9, -4, -1, 2, 3);
    send_item(MODE_LT, 1, 1, 2, 1, 1, 3);
    send_item(MODE_GT, 1, 1, 2, 1, 1, 3);
    send_item(MODE_LE, 2, 2, 4, 2, 1, 2);
    send_item(MODE_GE, -1, 3, 6, -1, 1, 2);
    // zero operand denominators
    send_item(MODE_ADD, 1, 1, 0, 1, 1, 2);
    send_item(MODE_LT, 1, 1, 2, 1, 1, 0);
    // divide by a zero value
    send_item(MODE_DIV, 3, 1, 2, 0, 0, 1);
    send_item(MODE_DIV, 3, 1, 2, -1, 2, 2);
    // extremes and overflow
    send_item(MODE_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0, 1);
    send_item(MODE_SUB, 32'h8000_0000, 0, 1, 1, 0, 1);
    send_item(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_MUL, 32'h7FFF_FFFF, 0, 1, 32'h7FFF_FFFF, 0, 1);
    send_item(MODE_DIV, 1, 0, 1, 0, 1, 32'h7FFF_FFFF);
    send_item(MODE_ADD, 0, 1, 32'h7FFF_FFFF, 0, 1, 32'h7FFF_FFFE);
    send_item(MODE_GE, 32'h8000_0000, 0, 1, 32'h7FFF_FFFF, 0, 1);
    send_item(MODE_LE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_SUB, 0, 0, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF);
    send_item(MODE_ADD, 4, 0, 1, -4, 0, 1);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 400) send_idle_on = 0;
      if (i == 500) recv_idle_on = 0;
      if (i == 700) begin
        send_idle_on = 1;
        recv_idle_on = 1;
      end
      if (i == 900) hold_req = 1;
      m = mode_t'($urandom_range(7));
      send_item(m, rand_value(0), rand_value(0), rand_value(1),
                rand_value(0), rand_value(0), rand_value(1));
    end
    in_tvalid <= 0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
